// File: rtl/graph_bridge_finder_unit_macros.svh
// Assertion macros for the graph bridge finder unit.
// No dependencies; the including module must provide clk_i and rst_ni.
`ifndef GRAPH_BRIDGE_FINDER_UNIT_MACROS_SVH
`define GRAPH_BRIDGE_FINDER_UNIT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define GBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define GBF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/gbf_pkg.sv
// Package of the graph bridge finder: beat types, action codes, widths.
// No dependencies.
package gbf_pkg;

  localparam int unsigned VERTEX_W         = 6;
  localparam int unsigned TIME_W           = 7;
  localparam int unsigned COUNT_W          = 7;
  localparam int unsigned MAX_VERTICES_DEF = 64;
  localparam int unsigned MAX_ENTRIES_DEF  = 256;
  localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_RUN    = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]          action;
    logic [VERTEX_W-1:0] vertex;
    logic [VERTEX_W-1:0] neighbor;
    logic [VERTEX_W-1:0] start_vertex;
  } item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] bridge_parent;
    logic [VERTEX_W-1:0] bridge_child;
    logic                is_bridge;
    logic                overflow;
    logic                last;
  } result_t;

endpackage

// File: rtl/graph_bridge_finder_unit.sv
// Bridge finder over per-vertex adjacency lists held in on-chip memories.
// Depends on gbf_pkg and graph_bridge_finder_unit_macros.svh.
//
// Usage: a beat is taken when start_i is high and busy_o is low. A clear
// beat leaves busy_o low. An append beat that is stored keeps busy_o high
// through S_APP_LINK and S_APP_FIN: the tail pointer is read from its
// memory, then the entry and the link from the old tail are written, then the
// entry's end marker; an append dropped on a full store leaves busy_o low.
// A run beat walks the graph depth first; each adjacency entry scanned
// passes S_ERD and S_ECHK (and S_LOW when the neighbor is already visited,
// for the read of its low time), each push S_HEAD for the head pointer read,
// each pop S_ERD and S_POP, and the restart scan S_RESTART for each vertex
// index passed, then S_FLUSH. The entry memory's one registered read port
// sets this pace. Results come out as single-cycle strobes on result_valid_o
// and cannot be stalled by the receiver; bridges appear in finish order, each
// reported one step late so that the final one can carry last, and a run
// without bridges gives one result with is_bridge low. No reset sweep is
// needed: list heads use per-vertex valid bits.
`include "graph_bridge_finder_unit_macros.svh"

module graph_bridge_finder_unit #(
  parameter int unsigned MAX_VERTICES = gbf_pkg::MAX_VERTICES_DEF,
  parameter int unsigned MAX_ENTRIES  = gbf_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  gbf_pkg::item_t                item_i,
  input  logic                          cfg_we_i,
  input  logic [gbf_pkg::COUNT_W-1:0]   cfg_wdata_i,
  output logic                          result_valid_o,
  output gbf_pkg::result_t              result_o
);
  import gbf_pkg::*;

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned EW = $clog2(MAX_ENTRIES + 1);   // pointer incl. end marker
  localparam int unsigned VA = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned DW = $clog2(MAX_VERTICES + 1);
  localparam logic [EW-1:0] MARK = EW'(MAX_ENTRIES);
  localparam logic [COUNT_W-1:0] NMAX = COUNT_W'(MAX_VERTICES);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_APP_LINK = 10'b0000000010,
    S_APP_FIN  = 10'b0000000100,
    S_HEAD     = 10'b0000001000,
    S_ERD      = 10'b0000010000,
    S_ECHK     = 10'b0000100000,
    S_LOW      = 10'b0001000000,
    S_POP      = 10'b0010000000,
    S_RESTART  = 10'b0100000000,
    S_FLUSH    = 10'b1000000000
  } state_e;

  // Memories
  logic [VERTEX_W-1:0] nb_mem   [MAX_ENTRIES];
  logic [EW-1:0]       nx_mem   [MAX_ENTRIES];
  logic [EW-1:0]       head_mem [MAX_VERTICES];
  logic [EW-1:0]       tail_mem [MAX_VERTICES];
  logic [TIME_W-1:0]   et_mem   [MAX_VERTICES];
  logic [TIME_W-1:0]   low_mem  [MAX_VERTICES];
  logic [VERTEX_W-1:0] stk_mem  [MAX_VERTICES];

  state_e state_q, state_d;
  logic [COUNT_W-1:0]      vcount_q;
  logic [EW-1:0]           used_q, used_d;
  logic                    ovf_q, ovf_d;
  logic [MAX_VERTICES-1:0] lvalid_q, lvalid_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [VA-1:0]           app_v_q, app_v_d;
  logic [VERTEX_W-1:0]     app_nb_q, app_nb_d;
  logic [AW-1:0]           app_e_q, app_e_d;
  logic [VERTEX_W-1:0]     cur_q, cur_d, par_q, par_d;
  logic                    has_par_q, has_par_d;
  logic [TIME_W-1:0]       lowv_q, lowv_d;
  logic [EW-1:0]           e_q, e_d;
  logic [DW-1:0]           depth_q, depth_d;
  logic [TIME_W-1:0]       time_q, time_d;
  logic [COUNT_W-1:0]      rs_q, rs_d;
  logic                    pend_q, pend_d;
  logic [VERTEX_W-1:0]     pend_p_q, pend_p_d, pend_c_q, pend_c_d;
  logic                    res_valid_q, res_valid_d;
  result_t                 res_q, res_d;

  // Registered read data
  logic [EW-1:0]       tail_rd_q, head_rd_q, nx_rd_q;
  logic [VERTEX_W-1:0] nb_rd_q, stk_rd_q;
  logic [TIME_W-1:0]   low_rd_q, et_rd_q;

  // Read addresses and write controls
  logic [VA-1:0]       head_ra, low_ra, stk_ra;
  logic                low_we, push_we, head_we, nb_we, nx_we;
  logic [VA-1:0]       low_wa, push_wa;
  logic [TIME_W-1:0]   low_wd;
  logic [TIME_W-1:0]   push_time;
  logic [AW-1:0]       nx_wa;
  logic [EW-1:0]       nx_wd;
  logic [COUNT_W-1:0]  n_eff;
  logic                accept;

  assign n_eff  = (vcount_q > NMAX) ? NMAX : vcount_q;
  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    logic [VERTEX_W-1:0] push_v;
    logic                do_push;
    logic                push_root;
    state_d     = state_q;
    used_d      = used_q;
    ovf_d       = ovf_q;
    lvalid_d    = lvalid_q;
    visited_d   = visited_q;
    app_v_d     = app_v_q;
    app_nb_d    = app_nb_q;
    app_e_d     = app_e_q;
    cur_d       = cur_q;
    par_d       = par_q;
    has_par_d   = has_par_q;
    lowv_d      = lowv_q;
    e_d         = e_q;
    depth_d     = depth_q;
    time_d      = time_q;
    rs_d        = rs_q;
    pend_d      = pend_q;
    pend_p_d    = pend_p_q;
    pend_c_d    = pend_c_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    head_ra     = cur_q[VA-1:0];
    low_ra      = par_q[VA-1:0];
    stk_ra      = VA'(depth_q - DW'(3));
    low_we      = 1'b0;
    low_wa      = cur_q[VA-1:0];
    low_wd      = lowv_q;
    head_we     = 1'b0;
    nb_we       = 1'b0;
    nx_we       = 1'b0;
    nx_wa       = app_e_q;
    nx_wd       = MARK;
    do_push     = 1'b0;
    push_root   = 1'b0;
    push_v      = '0;
    push_time   = time_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (item_i.action)
            ACT_CLEAR: begin
              lvalid_d = '0;
              used_d   = '0;
              ovf_d    = 1'b0;
            end
            ACT_APPEND: begin
              if (int'(item_i.vertex) < MAX_VERTICES &&
                  int'(item_i.neighbor) < MAX_VERTICES) begin
                if (used_q >= MARK) begin
                  ovf_d = 1'b1;
                end else begin
                  app_v_d  = item_i.vertex[VA-1:0];
                  app_nb_d = item_i.neighbor;
                  app_e_d  = used_q[AW-1:0];
                  used_d   = used_q + EW'(1);
                  state_d  = S_APP_LINK;
                end
              end
            end
            ACT_RUN: begin
              visited_d = '0;
              depth_d   = '0;
              time_d    = TIME_W'(1);
              rs_d      = COUNT_W'(1);
              pend_d    = 1'b0;
              if (n_eff >= COUNT_W'(2) && COUNT_W'(item_i.start_vertex) < n_eff) begin
                // The run's first push starts the clock at one.
                do_push   = 1'b1;
                push_root = 1'b1;
                push_v    = item_i.start_vertex;
                push_time = TIME_W'(1);
              end else begin
                state_d = S_RESTART;
              end
            end
            default: ;
          endcase
        end
      end
      S_APP_LINK: begin
        nb_we = 1'b1;
        if (lvalid_q[app_v_q]) begin
          nx_we = 1'b1;
          nx_wa = tail_rd_q[AW-1:0];
          nx_wd = EW'(app_e_q);
        end else begin
          head_we           = 1'b1;
          lvalid_d[app_v_q] = 1'b1;
        end
        state_d = S_APP_FIN;
      end
      S_APP_FIN: begin
        nx_we   = 1'b1;
        state_d = S_IDLE;
      end
      S_HEAD: begin
        e_d     = lvalid_q[cur_q[VA-1:0]] ? head_rd_q : MARK;
        state_d = S_ERD;
      end
      S_ERD: begin
        if (e_q >= MARK) begin
          // List exhausted: pop the top vertex.
          depth_d = depth_q - DW'(1);
          if (depth_q == DW'(1)) begin
            state_d = S_RESTART;
          end else begin
            head_ra = par_q[VA-1:0];
            state_d = S_POP;
          end
        end else begin
          state_d = S_ECHK;
        end
      end
      S_ECHK: begin
        e_d = nx_rd_q;
        if (COUNT_W'(nb_rd_q) >= n_eff || (has_par_q && nb_rd_q == par_q)) begin
          state_d = S_ERD;
        end else if (visited_q[nb_rd_q[VA-1:0]]) begin
          low_ra  = nb_rd_q[VA-1:0];
          state_d = S_LOW;
        end else begin
          do_push = 1'b1;
          push_v  = nb_rd_q;
        end
      end
      S_LOW: begin
        if (low_rd_q < lowv_q) begin
          lowv_d = low_rd_q;
          low_we = 1'b1;
          low_wd = low_rd_q;
        end
        state_d = S_ERD;
      end
      S_POP: begin
        // par_q is the new top; fold the child's low into it.
        if (lowv_q < low_rd_q) begin
          low_we = 1'b1;
          low_wa = par_q[VA-1:0];
          low_wd = lowv_q;
        end else begin
          lowv_d = low_rd_q;
        end
        if (lowv_q > et_rd_q) begin
          if (pend_q) begin
            res_valid_d = 1'b1;
            res_d       = '{bridge_parent: pend_p_q, bridge_child: pend_c_q,
                            is_bridge: 1'b1, overflow: ovf_q, last: 1'b0};
          end
          pend_d   = 1'b1;
          pend_p_d = par_q;
          pend_c_d = cur_q;
        end
        cur_d     = par_q;
        par_d     = stk_rd_q;
        has_par_d = depth_q >= DW'(2);
        e_d       = lvalid_q[par_q[VA-1:0]] ? head_rd_q : MARK;
        state_d   = S_ERD;
      end
      S_RESTART: begin
        if (rs_q >= n_eff) begin
          state_d = S_FLUSH;
        end else if (!visited_q[rs_q[VA-1:0]]) begin
          do_push   = 1'b1;
          push_root = 1'b1;
          push_v    = VERTEX_W'(rs_q);
        end else begin
          rs_d = rs_q + COUNT_W'(1);
        end
      end
      S_FLUSH: begin
        res_valid_d = 1'b1;
        if (pend_q) begin
          res_d = '{bridge_parent: pend_p_q, bridge_child: pend_c_q,
                    is_bridge: 1'b1, overflow: ovf_q, last: 1'b1};
        end else begin
          res_d = '{bridge_parent: '0, bridge_child: '0,
                    is_bridge: 1'b0, overflow: ovf_q, last: 1'b1};
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // Push: stack, visit mark, times; then fetch the new top's list head.
    if (do_push) begin
      visited_d[push_v[VA-1:0]] = 1'b1;
      low_we    = 1'b1;
      low_wa    = push_v[VA-1:0];
      low_wd    = push_time;
      lowv_d    = push_time;
      time_d    = push_time + TIME_W'(1);
      depth_d   = depth_q + DW'(1);
      par_d     = push_root ? '0 : cur_q;
      has_par_d = !push_root;
      cur_d     = push_v;
      head_ra   = push_v[VA-1:0];
      state_d   = S_HEAD;
    end
    push_we = do_push;
    push_wa = push_v[VA-1:0];
  end

  // Entry store
  always_ff @(posedge clk_i) begin
    if (nb_we) nb_mem[app_e_q] <= app_nb_q;
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    nb_rd_q <= nb_mem[e_q[AW-1:0]];
    nx_rd_q <= nx_mem[e_q[AW-1:0]];
  end

  // List heads and tails
  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[app_v_q] <= EW'(app_e_q);
    if (state_q == S_APP_LINK) tail_mem[app_v_q] <= EW'(app_e_q);
    head_rd_q <= head_mem[head_ra];
    tail_rd_q <= tail_mem[item_i.vertex[VA-1:0]];
  end

  // Search state: times and stack
  always_ff @(posedge clk_i) begin
    if (low_we) low_mem[low_wa] <= low_wd;
    if (push_we) begin
      et_mem[push_wa]             <= push_time;
      stk_mem[depth_q[VA-1:0]]    <= VERTEX_W'(push_wa);
    end
    low_rd_q <= low_mem[low_ra];
    et_rd_q  <= et_mem[par_q[VA-1:0]];
    stk_rd_q <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcount_q    <= VCOUNT_RESET;
      used_q      <= '0;
      ovf_q       <= 1'b0;
      lvalid_q    <= '0;
      visited_q   <= '0;
      depth_q     <= '0;
      time_q      <= '0;
      rs_q        <= '0;
      pend_q      <= 1'b0;
      has_par_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      used_q      <= used_d;
      ovf_q       <= ovf_d;
      lvalid_q    <= lvalid_d;
      visited_q   <= visited_d;
      depth_q     <= depth_d;
      time_q      <= time_d;
      rs_q        <= rs_d;
      pend_q      <= pend_d;
      has_par_q   <= has_par_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    app_v_q  <= app_v_d;
    app_nb_q <= app_nb_d;
    app_e_q  <= app_e_d;
    cur_q    <= cur_d;
    par_q    <= par_d;
    lowv_q   <= lowv_d;
    e_q      <= e_d;
    pend_p_q <= pend_p_d;
    pend_c_q <= pend_c_d;
    res_q    <= res_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  `GBF_ASSERT(a_last_ends_run, result_valid_o && result_o.last |-> !busy_o, "last result while busy")
  `GBF_ASSERT(a_mid_in_run, result_valid_o && !result_o.last |-> busy_o, "non-final result outside run")
  `GBF_ASSERT(a_none_is_last, result_valid_o && !result_o.is_bridge |-> result_o.last, "empty result not final")
  `GBF_ASSERT(a_run_busy, accept && item_i.action == ACT_RUN |=> busy_o, "run accepted but not busy")
  `GBF_ASSERT_ALWAYS(a_depth_bound, depth_q <= DW'(MAX_VERTICES), "stack depth out of range")

endmodule
